[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("imd assertion failed");
`define IMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imd assertion failed");
`else
`define IMD_ASSERT(lbl, prop)
`define IMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/imd_pkg.sv]
// ----------------------------------------------------------------------------
// imd_pkg
// shared constants, types and the text table of the metadata deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imd_pkg;

  localparam int TEXT_DEPTH  = 4096;
  localparam int STORE_DEPTH = 2 * TEXT_DEPTH;
  localparam int POS_W       = $clog2(TEXT_DEPTH);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int          INTERVAL_W     = 16;
  localparam logic [15:0] INTERVAL_RESET = 16'd16000;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    Q_AUDIO = 2'd0,
    Q_TEXT  = 2'd1,
    Q_END   = 2'd2,
    Q_SWAP  = 2'd3
  } qop_e;

  typedef struct packed {
    qop_e       op;
    logic [7:0] data;
    logic       title_pos;
    logic [3:0] pos;
  } q_entry_t;

  // blank title text; positions one to twelve are also the title prefix
  function automatic logic [7:0] text_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      12'd0:   c = 8'h01;
      12'd1:   c = "S";
      12'd2:   c = "t";
      12'd3:   c = "r";
      12'd4:   c = "e";
      12'd5:   c = "a";
      12'd6:   c = "m";
      12'd7:   c = "T";
      12'd8:   c = "i";
      12'd9:   c = "t";
      12'd10:  c = "l";
      12'd11:  c = "e";
      12'd12:  c = "=";
      12'd13:  c = "'";
      12'd14:  c = "'";
      12'd15:  c = ";";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/imd_if.sv]
// ----------------------------------------------------------------------------
// imd interfaces
// valid/ready channels for stream bytes, results and the interval register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface imd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface imd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       text_changed;
  modport source (output valid, output kind, output out_byte, output text_changed,
                  input ready);
  modport sink   (input valid, input kind, input out_byte, input text_changed,
                  output ready);
endinterface

interface imd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] meta_interval;
  modport source (output valid, output meta_interval, input ready);
  modport sink   (input valid, input meta_interval, output ready);
endinterface

[rtl/imd_ram.sv]
// ----------------------------------------------------------------------------
// imd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/imd_front.sv]
// ----------------------------------------------------------------------------
// imd_front
// byte classification, text store access and text comparison
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  imd_in_if.sink            in_i,
  imd_cfg_if.sink           cfg_i,
  output logic              push_o,
  output imd_pkg::q_entry_t push_data_o,
  input  logic              push_ready_i
);

  import imd_pkg::*;

  typedef enum logic [2:0] {
    F_AUDIO = 3'd0,
    F_LEN   = 3'd1,
    F_END   = 3'd2,
    F_TEXT  = 3'd3,
    F_TERM  = 3'd4
  } fop_e;

  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [INTERVAL_W-1:0] audio_cnt_q, audio_cnt_d;
  logic                  in_block_q, in_block_d;
  logic [POS_W-1:0]      blk_len_q, blk_len_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  cur_half_q, cur_half_d;
  logic                  reset_text_q, reset_text_d;
  logic                  eq_q, eq_d;
  logic                  settled_q, settled_d;

  logic                  s1_valid_q, s1_valid_d;
  fop_e                  s1_op_q, s1_op_d;
  logic [7:0]            s1_data_q, s1_data_d;
  logic [POS_W-1:0]      s1_pos_q, s1_pos_d;

  fop_e                  op;
  logic                  accept;
  logic                  ram_en;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [7:0]            ram_wdata;
  logic [7:0]            ram_rdata;
  logic [7:0]            cur_byte;
  logic                  neq;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !s1_valid_q || push_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign push_o      = s1_valid_q && push_ready_i;

  // classify the incoming byte
  always_comb begin
    op = F_AUDIO;
    if (!in_block_q) begin
      if (audio_cnt_q < interval_q) begin
        op = F_AUDIO;
      end else if (in_i.in_byte == 8'd0) begin
        op = F_END;
      end else begin
        op = F_LEN;
      end
    end else if ({1'b0, pos_q} + (POS_W + 1)'(1) < {1'b0, blk_len_q}) begin
      op = F_TEXT;
    end else begin
      op = F_TERM;
    end
  end

  always_comb begin
    interval_d  = interval_q;
    audio_cnt_d = audio_cnt_q;
    in_block_d  = in_block_q;
    blk_len_d   = blk_len_q;
    pos_d       = pos_q;
    if (cfg_i.valid && cfg_i.ready) begin
      interval_d = cfg_i.meta_interval;
    end
    if (accept) begin
      unique case (op)
        F_AUDIO: audio_cnt_d = audio_cnt_q + INTERVAL_W'(1);
        F_END:   audio_cnt_d = '0;
        F_LEN: begin
          blk_len_d  = {in_i.in_byte, 4'h1};
          pos_d      = POS_W'(1);
          in_block_d = 1'b1;
        end
        F_TEXT:  pos_d = pos_q + POS_W'(1);
        F_TERM: begin
          in_block_d  = 1'b0;
          audio_cnt_d = '0;
          pos_d       = '0;
        end
        default: pos_d = pos_q;
      endcase
    end
  end

  // spare half takes the new text, current half is read for comparison
  assign ram_en    = accept && ((op == F_TEXT) || (op == F_TERM));
  assign ram_waddr = {~cur_half_q, pos_q};
  assign ram_raddr = {cur_half_q, pos_q};
  assign ram_wdata = (op == F_TEXT) ? in_i.in_byte : 8'd0;

  imd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (ram_en),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_op_d    = s1_op_q;
    s1_data_d  = s1_data_q;
    s1_pos_d   = s1_pos_q;
    if (accept) begin
      s1_valid_d = (op != F_LEN);
      s1_op_d    = op;
      s1_data_d  = in_i.in_byte;
      s1_pos_d   = pos_q;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  // reset text is served from the table until the first swap
  assign cur_byte = reset_text_q ? text_char(s1_pos_q) : ram_rdata;
  assign neq      = !eq_q || (!settled_q && (cur_byte != 8'd0));

  always_comb begin
    eq_d         = eq_q;
    settled_d    = settled_q;
    cur_half_d   = cur_half_q;
    reset_text_d = reset_text_q;
    if (push_o) begin
      case (s1_op_q)
        F_TEXT: begin
          if (!settled_q) begin
            if (s1_data_q != cur_byte) begin
              eq_d      = 1'b0;
              settled_d = 1'b1;
            end else if (s1_data_q == 8'd0) begin
              settled_d = 1'b1;
            end
          end
        end
        F_TERM: begin
          eq_d      = 1'b1;
          settled_d = 1'b0;
          if (neq) begin
            cur_half_d   = ~cur_half_q;
            reset_text_d = 1'b0;
          end
        end
        default: eq_d = eq_q;
      endcase
    end
  end

  always_comb begin
    push_data_o.data      = s1_data_q;
    push_data_o.pos       = s1_pos_q[3:0];
    push_data_o.title_pos = (s1_pos_q >= POS_W'(1)) && (s1_pos_q <= POS_W'(12));
    case (s1_op_q)
      F_AUDIO: push_data_o.op = Q_AUDIO;
      F_TEXT:  push_data_o.op = Q_TEXT;
      F_TERM:  push_data_o.op = neq ? Q_SWAP : Q_END;
      default: push_data_o.op = Q_END;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= INTERVAL_RESET;
      audio_cnt_q  <= '0;
      in_block_q   <= 1'b0;
      blk_len_q    <= '0;
      pos_q        <= '0;
      cur_half_q   <= 1'b0;
      reset_text_q <= 1'b1;
      eq_q         <= 1'b1;
      settled_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      interval_q   <= interval_d;
      audio_cnt_q  <= audio_cnt_d;
      in_block_q   <= in_block_d;
      blk_len_q    <= blk_len_d;
      pos_q        <= pos_d;
      cur_half_q   <= cur_half_d;
      reset_text_q <= reset_text_d;
      eq_q         <= eq_d;
      settled_q    <= settled_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= s1_op_d;
    s1_data_q <= s1_data_d;
    s1_pos_q  <= s1_pos_d;
  end

  `IMD_ASSERT(a_pos_in_block, in_block_q |-> (pos_q < blk_len_q))
  `IMD_ASSERT_NEXT(a_s1_hold, s1_valid_q && !push_ready_i, s1_valid_q && $stable(s1_data_q))
  `IMD_ASSERT_NEXT(a_swap_flip, push_o && (s1_op_q == F_TERM) && neq, cur_half_q != $past(cur_half_q))

endmodule

[rtl/imd_fifo.sv]
// ----------------------------------------------------------------------------
// imd_fifo
// short queue decoupling the front from the result stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  imd_pkg::q_entry_t push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output imd_pkg::q_entry_t pop_data_o,
  input  logic              pop_i
);

  import imd_pkg::*;

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `IMD_ASSERT(a_cnt_range, cnt_q <= QCNT_W'(QUEUE_DEPTH))
  `IMD_ASSERT_NEXT(a_drain, do_pop && !do_push, cnt_q == $past(cnt_q) - QCNT_W'(1))
  `IMD_ASSERT_NEXT(a_fill, do_push && !do_pop, cnt_q == $past(cnt_q) + QCNT_W'(1))

endmodule

[rtl/imd_back.sv]
// ----------------------------------------------------------------------------
// imd_back
// prefix check, halt on format error and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  imd_pkg::q_entry_t pop_data_i,
  output logic              pop_o,
  imd_out_if.source         out_o
);

  import imd_pkg::*;

  logic       out_valid_q, out_valid_d;
  kind_e      out_kind_q, out_kind_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_changed_q, out_changed_d;
  logic       prefix_ok_q, prefix_ok_d;
  logic       halted_q, halted_d;
  logic       take;

  // once halted, queued transactions are drained and dropped
  assign pop_o = pop_valid_i && (halted_q || !out_valid_q || out_o.ready);
  assign take  = pop_o && !halted_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_kind_d    = out_kind_q;
    out_data_d    = out_data_q;
    out_changed_d = out_changed_q;
    prefix_ok_d   = prefix_ok_q;
    halted_d      = halted_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      out_valid_d   = 1'b1;
      out_data_d    = 8'd0;
      out_changed_d = 1'b0;
      unique case (pop_data_i.op)
        Q_AUDIO: begin
          out_kind_d = KIND_AUDIO;
          out_data_d = pop_data_i.data;
        end
        Q_TEXT: begin
          out_kind_d = KIND_TEXT;
          out_data_d = pop_data_i.data;
          if (pop_data_i.title_pos &&
              (pop_data_i.data != text_char(POS_W'(pop_data_i.pos)))) begin
            prefix_ok_d = 1'b0;
          end
        end
        Q_END: begin
          out_kind_d  = KIND_END;
          prefix_ok_d = 1'b1;
        end
        Q_SWAP: begin
          if (prefix_ok_q) begin
            out_kind_d    = KIND_END;
            out_changed_d = 1'b1;
          end else begin
            out_kind_d = KIND_ERROR;
            halted_d   = 1'b1;
          end
          prefix_ok_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prefix_ok_q <= 1'b1;
      halted_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      prefix_ok_q <= prefix_ok_d;
      halted_q    <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q    <= out_kind_d;
    out_data_q    <= out_data_d;
    out_changed_q <= out_changed_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.out_byte     = out_data_q;
  assign out_o.text_changed = out_changed_q;

  `IMD_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `IMD_ASSERT(a_error_shown, $rose(halted_q) |-> out_valid_q && (out_kind_q == KIND_ERROR))
  `IMD_ASSERT(a_zero_byte, out_valid_q && ((out_kind_q == KIND_END) || (out_kind_q == KIND_ERROR)) |-> (out_data_q == 8'd0))

endmodule

[rtl/inline_metadata_deframer_unit.sv]
// ----------------------------------------------------------------------------
// inline_metadata_deframer_unit
// splits a byte stream with inline metadata blocks into audio, text, block
// end and error transactions, and keeps the current title text
//
//   channel  dir  transaction payload
//   in_i     in   in_byte
//   cfg_i    in   meta_interval
//   out_o    out  kind, out_byte, text_changed
//
// one byte per cycle sustained while out_o is ready; a byte taken on in_i
// passes the classification stage, which also waits for the registered
// read of the text store, then the queue and the result register to reach out_o
// no clearing pass after reset: the reset title text is held as a constant
// until the first accepted title replaces it
// a four-entry queue between classification and result register lets
// out_o stall while in_i keeps flowing until the queue fills
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inline_metadata_deframer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  imd_in_if.sink    in_i,
  imd_cfg_if.sink   cfg_i,
  imd_out_if.source out_o
);

  import imd_pkg::*;

  logic     push;
  logic     push_ready;
  q_entry_t push_data;
  logic     pop_valid;
  logic     pop;
  q_entry_t pop_data;

  imd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  imd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  imd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
